### sv/sls_pkg.sv
// Package for the source line splicer.
// Holds the character codes and the default widths shared by all files but sls_if.
// Depends on nothing.
package sls_pkg;

  // Character codes that the splicer looks for.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BSL = 8'h5C;

  // Default counter widths.
  localparam int unsigned LINE_BITS_DEF = 20;
  localparam int unsigned COL_BITS_DEF  = 12;

  // Number of results one request can cause.
  localparam int unsigned MAX_RES = 2;

  // Push from the step logic into the result queue.
  typedef struct packed {
    logic       one;  // at least one result is written
    logic       two;  // a second result is written as well
  } sls_push_t;

endpackage

### sv/sls_if.sv
// Handshake channels of the source line splicer.
// One channel carries raw bytes in, the other carries located characters out.
// Depends on nothing.
interface sls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

interface sls_out_if #(
  parameter int unsigned LINE_BITS = 20,
  parameter int unsigned COL_BITS  = 12
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_char;
  logic                 out_eof;
  logic [LINE_BITS-1:0] out_line;
  logic [COL_BITS-1:0]  out_col;
  logic                 out_last;

  modport source (output valid, output out_char, output out_eof, output out_line,
                  output out_col, output out_last, input ready);
  modport sink (input valid, input out_char, input out_eof, input out_line,
                input out_col, input out_last, output ready);
endinterface

### sv/sls_step.sv
// Per-request step logic of the source line splicer: splice state, line and
// column counters, and the up to two results each accepted request causes.
// Depends on sls_pkg.
module sls_step #(
  parameter int unsigned LINE_BITS = sls_pkg::LINE_BITS_DEF,
  parameter int unsigned COL_BITS  = sls_pkg::COL_BITS_DEF,
  parameter int unsigned RES_W     = 8 + 1 + LINE_BITS + COL_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  output sls_pkg::sls_push_t push_o,
  output logic [RES_W-1:0]  res0_o,
  output logic [RES_W-1:0]  res1_o
);
  import sls_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [COL_BITS-1:0]  COL_ONE  = COL_BITS'(1);

  logic                 skip_q, skip_d;
  logic                 held_q, held_d;
  logic                 lastnl_q, lastnl_d;
  logic                 ended_q, ended_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [COL_BITS-1:0]  col_q, col_d;

  logic                 line_inc_sat;
  logic [LINE_BITS-1:0] line_inc;
  logic [COL_BITS-1:0]  col_inc;
  logic [COL_BITS-1:0]  col_inc2;
  logic [7:0]           c;
  logic                 c_is_lf;

  // Results: character, EOF flag, line, column, last flag.
  logic [7:0]           r0_char, r1_char;
  logic                 r0_eof, r1_eof;
  logic [LINE_BITS-1:0] r0_line, r1_line;
  logic [COL_BITS-1:0]  r0_col, r1_col;
  logic                 r0_last;

  // Saturating increments of the counters.
  assign line_inc_sat = (line_q == '1);
  assign line_inc     = line_inc_sat ? line_q : line_q + LINE_ONE;
  assign col_inc      = (col_q == '1) ? col_q : col_q + COL_ONE;
  assign col_inc2     = (col_inc == '1) ? col_inc : col_inc + COL_ONE;

  // A CR is taken as LF.
  assign c       = (byte_i == CH_CR) ? CH_LF : byte_i;
  assign c_is_lf = (c == CH_LF);

  // Next state and results for the offered request.
  always_comb begin
    skip_d   = skip_q;
    held_d   = held_q;
    lastnl_d = lastnl_q;
    ended_d  = ended_q;
    line_d   = line_q;
    col_d    = col_q;
    push_o   = '0;
    r0_char  = '0;
    r0_eof   = 1'b0;
    r0_line  = line_q;
    r0_col   = col_q;
    r0_last  = 1'b1;
    r1_char  = '0;
    r1_eof   = 1'b0;
    r1_line  = line_q;
    r1_col   = col_q;
    priority if (ended_q) begin
      // After the end mark every request gets one EOF.
      push_o.one = 1'b1;
      r0_eof     = 1'b1;
    end else if (end_i) begin
      ended_d  = 1'b1;
      skip_d   = 1'b0;
      held_d   = 1'b0;
      lastnl_d = 1'b1;
      if (held_q) begin
        // The added newline splices the held backslash away.
        line_d     = line_inc;
        col_d      = COL_ONE;
        push_o.one = 1'b1;
        r0_eof     = 1'b1;
        r0_line    = line_inc;
        r0_col     = COL_ONE;
      end else if (!lastnl_q) begin
        // Add the missing final newline, then EOF.
        line_d     = line_inc;
        col_d      = COL_ONE;
        push_o.one = 1'b1;
        push_o.two = 1'b1;
        r0_char    = CH_LF;
        r0_last    = 1'b0;
        r1_eof     = 1'b1;
        r1_line    = line_inc;
        r1_col     = COL_ONE;
      end else begin
        push_o.one = 1'b1;
        r0_eof     = 1'b1;
      end
    end else if (skip_q && (byte_i == CH_LF)) begin
      // LF right after CR is dropped.
      skip_d = 1'b0;
    end else begin
      skip_d   = (byte_i == CH_CR);
      lastnl_d = c_is_lf;
      if (held_q) begin
        held_d = 1'b0;
        if (c_is_lf) begin
          // Backslash and newline vanish; the line still moves on.
          line_d = line_inc;
          col_d  = COL_ONE;
        end else begin
          // The held backslash comes out at its own position first.
          push_o.one = 1'b1;
          r0_char    = CH_BSL;
          col_d      = col_inc;
          if (c == CH_BSL) begin
            held_d = 1'b1;
          end else begin
            push_o.two = 1'b1;
            r0_last    = 1'b0;
            r1_char    = c;
            r1_col     = col_inc;
            col_d      = col_inc2;
          end
        end
      end else if (c == CH_BSL) begin
        held_d = 1'b1;
      end else begin
        push_o.one = 1'b1;
        r0_char    = c;
        if (c_is_lf) begin
          line_d = line_inc;
          col_d  = COL_ONE;
        end else begin
          col_d = col_inc;
        end
      end
    end
  end

  assign res0_o = {r0_char, r0_eof, r0_line, r0_col, r0_last};
  assign res1_o = {r1_char, r1_eof, r1_line, r1_col, 1'b1};

  // State registers move only when a request is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= 1'b0;
      held_q   <= 1'b0;
      lastnl_q <= 1'b0;
      ended_q  <= 1'b0;
      line_q   <= LINE_ONE;
      col_q    <= COL_ONE;
    end else if (accept_i) begin
      skip_q   <= skip_d;
      held_q   <= held_d;
      lastnl_q <= lastnl_d;
      ended_q  <= ended_d;
      line_q   <= line_d;
      col_q    <= col_d;
    end
  end

endmodule

### sv/sls_resq.sv
// Result queue of the source line splicer: four registered entries that take
// up to two results per cycle and hand out one per cycle while the output is ready.
// Depends on sls_pkg.
module sls_resq #(
  parameter int unsigned RES_W = 34
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sls_pkg::sls_push_t push_i,
  input  logic [RES_W-1:0]   res0_i,
  input  logic [RES_W-1:0]   res1_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [RES_W-1:0]   data_o
);
  import sls_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_RES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;

  logic [RES_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    wr_next;
  logic             pop;
  logic [CW-1:0]    n_push;

  assign wr_next = wr_q + AW'(1);
  assign pop     = valid_o && ready_i;
  assign n_push  = CW'(push_i.one) + CW'(push_i.two);

  // Room for a full pair regardless of the output side this cycle.
  assign room_o  = (cnt_q <= CW'(DEPTH - MAX_RES));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Pointer and fill updates.
  always_comb begin
    wr_d  = wr_q + AW'(n_push);
    rd_d  = pop ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + n_push - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.one) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.two) begin
      mem_q[wr_next] <= res1_i;
    end
  end

endmodule

### sv/source_line_splicer_unit.sv
// Source line splicer: normalizes CR and CR LF to LF, removes backslash-newline
// pairs and tags each surviving character with its saturating line and column.
// Depends on sls_pkg, sls_in_if, sls_out_if, sls_step and sls_resq.
//
// One raw byte (or the end mark) is taken per request and yields zero, one or
// two results, the last of which carries out_last. The step logic works out the
// results in the cycle of acceptance and writes them into a four-entry result
// queue, which delivers one result per cycle from a register while the output is
// ready. A request is taken whenever the queue has room for two results, so input
// flows every cycle as long as the output keeps up; since the single output port
// drains one result per cycle, a stream in which every byte yields two results
// stalls the input. Results leave the queue in the order of their requests.
// After the end mark, every further request yields a single EOF result until
// reset.
module source_line_splicer_unit #(
  parameter int unsigned LINE_BITS = sls_pkg::LINE_BITS_DEF,
  parameter int unsigned COL_BITS  = sls_pkg::COL_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sls_in_if.sink    in_i,
  sls_out_if.source out_o
);
  import sls_pkg::*;

  localparam int unsigned RES_W = 8 + 1 + LINE_BITS + COL_BITS + 1;

  sls_push_t        push;
  sls_push_t        push_acc;
  logic [RES_W-1:0] res0, res1, head;
  logic             room;
  logic             accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  // Step logic: splice state and counters.
  sls_step #(
    .LINE_BITS(LINE_BITS),
    .COL_BITS (COL_BITS),
    .RES_W    (RES_W)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (in_i.in_byte),
    .end_i   (in_i.in_end),
    .push_o  (push),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  // Gate the push with the accept so idle cycles write nothing.
  assign push_acc.one = push.one && accept;
  assign push_acc.two = push.two && accept;

  sls_resq #(
    .RES_W(RES_W)
  ) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_acc),
    .res0_i (res0),
    .res1_i (res1),
    .room_o (room),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .data_o (head)
  );

  // Unpack the head entry onto the output channel.
  assign {out_o.out_char, out_o.out_eof, out_o.out_line, out_o.out_col,
          out_o.out_last} = head;

  // EOF always closes the results of its request.
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_eof) |-> out_o.out_last)
    else $error("EOF result without out_last");

  // Once EOF has gone out, nothing but EOF follows.
  a_eof_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.out_eof) |=> (!out_o.valid || out_o.out_eof))
    else $error("character result after EOF");

  // Input is only held off while results are waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with an empty result queue");

  // A request that causes a result makes the output valid in the next cycle.
  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_acc.one |=> out_o.valid)
    else $error("accepted result did not reach the output");

endmodule

### sim/sls_splice_checker.sv
// Checker for the source line splicer: watches both channels, predicts every result
// from the accepted requests and compares them in order.
// Depends on sls_pkg, sls_in_if and sls_out_if.
module sls_splice_checker #(
  parameter int unsigned LINE_BITS = sls_pkg::LINE_BITS_DEF,
  parameter int unsigned COL_BITS  = sls_pkg::COL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sls_in_if           req_i,
  sls_out_if          res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import sls_pkg::*;

  typedef struct packed {
    logic [7:0]           ch;
    logic                 eof;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  col;
    logic                 last;
  } located_char_t;

  // Shadow state of the splicer.
  logic                 cr_seen;
  logic                 bsl_held;
  logic                 nl_last;
  logic                 ended;
  logic [LINE_BITS-1:0] cur_line;
  logic [COL_BITS-1:0]  cur_col;

  located_char_t        step_res [2];
  int unsigned          step_n;
  located_char_t        due_q [$];
  int unsigned          bad_cnt;

  assign errors_o = bad_cnt;

  // Records one located character at the current position.
  task automatic emit(input logic [7:0] ch, input logic eof);
    step_res[step_n] = '{ch: ch, eof: eof, line: cur_line, col: cur_col, last: 1'b0};
    step_n++;
  endtask

  // Moves the position past one character; both counters saturate.
  task automatic move_past(input logic [7:0] ch);
    if (ch == CH_LF) begin
      if (cur_line != '1) cur_line++;
      cur_col = COL_BITS'(1);
    end else if (cur_col != '1) begin
      cur_col++;
    end
  endtask

  // Works out the results of one request and updates the shadow state.
  task automatic splice_request(input logic [7:0] b, input logic e);
    logic [7:0] c;
    step_n = 0;
    if (ended) begin
      emit(8'h00, 1'b1);
    end else if (e) begin
      ended   = 1'b1;
      cr_seen = 1'b0;
      // A held backslash is spliced away by the added newline.
      if (bsl_held) begin
        bsl_held = 1'b0;
        move_past(CH_LF);
      end else if (!nl_last) begin
        emit(CH_LF, 1'b0);
        move_past(CH_LF);
      end
      nl_last = 1'b1;
      emit(8'h00, 1'b1);
    end else begin
      c = b;
      // The LF of a CR LF pair vanishes.
      if (cr_seen) begin
        cr_seen = 1'b0;
        if (b == CH_LF) return;
      end
      if (b == CH_CR) begin
        c       = CH_LF;
        cr_seen = 1'b1;
      end
      nl_last = (c == CH_LF);
      if (bsl_held) begin
        bsl_held = 1'b0;
        if (c == CH_LF) begin
          move_past(CH_LF);
          return;
        end
        emit(CH_BSL, 1'b0);
        move_past(CH_BSL);
      end
      if (c == CH_BSL) begin
        bsl_held = 1'b1;
      end else begin
        emit(c, 1'b0);
        move_past(c);
      end
    end
  endtask

  // Prediction on accepted requests, comparison on accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    located_char_t want;
    located_char_t seen;
    if (!rst_ni) begin
      cr_seen   = 1'b0;
      bsl_held  = 1'b0;
      nl_last   = 1'b0;
      ended     = 1'b0;
      cur_line  = LINE_BITS'(1);
      cur_col   = COL_BITS'(1);
      bad_cnt   = 0;
      due_q.delete();
      pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        splice_request(req_i.in_byte, req_i.in_end);
        for (int k = 0; k < step_n; k++) begin
          want      = step_res[k];
          want.last = (k == step_n - 1);
          due_q.push_back(want);
        end
      end
      if (res_i.valid && res_i.ready) begin
        seen = '{ch: res_i.out_char, eof: res_i.out_eof, line: res_i.out_line,
                 col: res_i.out_col, last: res_i.out_last};
        if (due_q.size() == 0 || seen !== due_q[0]) begin
          if (bad_cnt < 10) begin
            if (due_q.size() == 0) begin
              $display("%0t: unexpected result char %h eof %b line %0d col %0d last %b",
                       $time, seen.ch, seen.eof, seen.line, seen.col, seen.last);
            end else begin
              want = due_q[0];
              $display("%0t: mismatch, expected char %h eof %b line %0d col %0d last %b",
                       $time, want.ch, want.eof, want.line, want.col, want.last);
              $display("%0t:           got      char %h eof %b line %0d col %0d last %b",
                       $time, seen.ch, seen.eof, seen.line, seen.col, seen.last);
            end
          end
          bad_cnt++;
        end
        if (due_q.size() != 0) void'(due_q.pop_front());
      end
      pending_o <= due_q.size();
    end
  end

endmodule

### sim/source_line_splicer_unit_tb.sv
// Testbench top for the source line splicer: drives raw bytes and the end mark,
// stalls the result side at random and gives the verdict from the checker's count.
// Depends on sls_pkg, sls_in_if, sls_out_if, source_line_splicer_unit and sls_splice_checker.
module source_line_splicer_unit_tb;
  import sls_pkg::*;

  localparam int unsigned LINE_BITS   = LINE_BITS_DEF;
  localparam int unsigned COL_BITS    = COL_BITS_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid = 1'b0;
  logic [7:0]  req_byte = 8'h00;
  logic        req_end = 1'b0;
  logic        take_res = 1'b0;
  logic        idle_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_cnt;
  int unsigned pending;

  sls_in_if req_ch ();
  sls_out_if #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS)) res_ch ();

  assign req_ch.valid   = req_valid;
  assign req_ch.in_byte = req_byte;
  assign req_ch.in_end  = req_end;
  assign res_ch.ready   = take_res;

  source_line_splicer_unit #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  sls_splice_checker #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .res_i     (res_ch),
    .errors_o  (fail_cnt),
    .pending_o (pending)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: ready drops in bursts of random length while idling is on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      take_res   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      take_res   <= 1'b0;
    end else begin
      take_res <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid && req_ch.ready) || (res_ch.valid && take_res)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, after an optional gap, and returns at its acceptance.
  task automatic send_req(input logic [7:0] b, input logic e);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_byte  <= b;
    req_end   <= e;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Holds off the sender until every predicted result has arrived.
  task automatic drain_pause();
    req_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Raw byte mix rich in CR, LF and backslash so that splices happen often.
  function automatic logic [7:0] raw_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_CR;
    if (r < 26) return CH_LF;
    if (r < 40) return CH_BSL;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] opening [$];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, CR LF and lone CR, splices by LF, by CR LF and by
    // lone CR, a backslash that is not spliced, and a backslash run.
    opening = '{8'h00, 8'hFF, "a", CH_LF, "b", CH_CR, CH_LF, "c", CH_CR, "d",
                CH_BSL, CH_LF, "e", CH_BSL, CH_CR, CH_LF, "f", CH_BSL, CH_CR, "g",
                CH_BSL, CH_BSL, CH_BSL, CH_LF, CH_CR, CH_CR};
    idle_on = 1'b1;
    foreach (opening[i]) send_req(opening[i], 1'b0);
    drain_pause();

    // Random chunks of raw bytes; the last chunk runs without idling.
    for (int chunk = 0; chunk < 10; chunk++) begin
      idle_on = (chunk != 9) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 45; i++) send_req(raw_byte(), 1'b0);
      if (chunk == 5) drain_pause();
    end

    // End of input after one of the interesting tails, then requests past the end.
    case ($urandom_range(0, 3))
      0: send_req(CH_BSL, 1'b0);
      1: send_req("z", 1'b0);
      2: send_req(CH_LF, 1'b0);
      default: send_req(CH_CR, 1'b0);
    endcase
    send_req(8'($urandom_range(0, 255)), 1'b1);
    for (int i = 0; i < 12; i++) begin
      send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end

    drain_pause();
    repeat (12) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sls_pkg.sv
sv/sls_if.sv
sv/sls_step.sv
sv/sls_resq.sv
sv/source_line_splicer_unit.sv
sim/sls_splice_checker.sv
sim/source_line_splicer_unit_tb.sv
